FILE: hdl/spc_pkg.sv
// Shared types and constants of the saliency peak centroid block.
// No dependencies; every other file imports this package.
package spc_pkg;

  // Frame geometry of the downsampled pixel stream.
  localparam int unsigned FRAME_WIDTH  = 320;
  localparam int unsigned FRAME_HEIGHT = 240;
  localparam int unsigned COL_W = $clog2(FRAME_WIDTH);
  localparam int unsigned ROW_W = $clog2(FRAME_HEIGHT);

  // Field and register widths.
  localparam int unsigned PIX_W    = 8;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned RAD_W    = 18;
  localparam int unsigned CNT_W    = 17;
  localparam int unsigned CFG_W    = 18;
  localparam int unsigned CFG_IDX_W = 2;

  // Coordinate sums must not wrap even when a frame never ends.
  localparam int unsigned SUM_W  = CNT_W + COL_W;
  localparam int unsigned DIVD_W = SUM_W + 1;
  localparam int unsigned DIVS_W = CNT_W + 1;
  localparam int unsigned Q_W    = COL_W;
  localparam int unsigned DIST_W = 2 * COL_W + 1;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
  localparam logic [PIX_W-1:0] LEVEL_MAX = {PIX_W{1'b1}};

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WEIGHT_COLOUR    = 2'd0,
    REG_WEIGHT_CONVERTED = 2'd1,
    REG_WEIGHT_MOTION    = 2'd2,
    REG_RADIUS_SQ        = 2'd3
  } cfg_reg_t;

  // One classified pixel travelling from the front to the back.
  typedef struct packed {
    logic             last;
    logic [ROW_W-1:0] y;
    logic [COL_W-1:0] x;
    logic [PIX_W-1:0] fused;
  } pix_t;

  // One result item.
  typedef struct packed {
    logic [CNT_W-1:0] peak_count;
    logic [PIX_W-1:0] peak_level;
    logic [7:0]       cent_row;
    logic [8:0]       cent_col;
    logic             frame_done;
    logic [PIX_W-1:0] fused_value;
  } result_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_START,
    BK_DIV,
    BK_EMIT
  } back_state_t;

endpackage

FILE: hdl/spc_front.sv
// Front end: accepts pixels, fuses the three maps and tags each item with its position.
// Depends on spc_pkg.
module spc_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [spc_pkg::PIX_W-1:0]     converted_value,
  input  logic [spc_pkg::PIX_W-1:0]     colour_value,
  input  logic [spc_pkg::PIX_W-1:0]     motion_value,
  input  logic                          frame_last,
  input  logic [spc_pkg::WEIGHT_W-1:0]  weight_colour,
  input  logic [spc_pkg::WEIGHT_W-1:0]  weight_converted,
  input  logic [spc_pkg::WEIGHT_W-1:0]  weight_motion,
  input  logic                          q_full,
  output logic                          q_push,
  output spc_pkg::pix_t                 q_data
);
  import spc_pkg::*;

  localparam int unsigned PROD_W = PIX_W + WEIGHT_W;
  localparam int unsigned ACC_W  = PROD_W + 3;

  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [PROD_W-1:0] p_conv, p_col, p_mot;
  logic [ACC_W-1:0]  acc;
  logic [ACC_W-WEIGHT_W-1:0] level;
  logic [PIX_W-1:0]  fused;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  // Weighted sum, rounded up to whole levels and saturated.
  always_comb begin
    p_conv = PROD_W'(converted_value) * PROD_W'(weight_converted);
    p_col  = PROD_W'(colour_value) * PROD_W'(weight_colour);
    p_mot  = PROD_W'(motion_value) * PROD_W'(weight_motion);
    acc    = ACC_W'(p_conv) + ACC_W'(p_col) + ACC_W'(p_mot) + ACC_W'({WEIGHT_W{1'b1}});
    level  = acc[ACC_W-1:WEIGHT_W];
    if (level > (ACC_W-WEIGHT_W)'(LEVEL_MAX)) begin
      fused = LEVEL_MAX;
    end else begin
      fused = level[PIX_W-1:0];
    end
  end

  always_comb begin
    q_data.last  = frame_last;
    q_data.y     = row;
    q_data.x     = col;
    q_data.fused = fused;
  end

  // Raster position; the last pixel of a frame returns it to the origin.
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (q_push) begin
      if (frame_last) begin
        col <= '0;
        row <= '0;
      end else if (col == COL_W'(FRAME_WIDTH - 1)) begin
        col <= '0;
        if (row == ROW_W'(FRAME_HEIGHT - 1)) begin
          row <= '0;
        end else begin
          row <= row + 1'b1;
        end
      end else begin
        col <= col + 1'b1;
      end
    end
  end

endmodule

FILE: hdl/spc_fifo.sv
// Short queue of classified pixels between the front and the back end.
// Depends on spc_pkg.
module spc_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  spc_pkg::pix_t wr_data,
  input  logic          pop,
  output spc_pkg::pix_t rd_data,
  output logic          full,
  output logic          empty
);
  import spc_pkg::*;

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  pix_t               entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [PTR_W:0]     count;

  assign full    = (count == (PTR_W+1)'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = entries[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

FILE: hdl/spc_div.sv
// Restoring divider, one quotient bit a cycle, for the centroid coordinates.
// Depends on spc_pkg; the quotient must be known to fit in Q_W bits.
module spc_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [spc_pkg::DIVD_W-1:0]  dividend,
  input  logic [spc_pkg::DIVS_W-1:0]  divisor,
  output logic                        done,
  output logic [spc_pkg::Q_W-1:0]     quotient
);
  import spc_pkg::*;

  localparam int unsigned CNT_BITS = $clog2(Q_W);

  logic [DIVD_W-1:0]   rem;
  logic [DIVD_W-1:0]   dshift;
  logic [CNT_BITS-1:0] step;
  logic                busy;
  logic                ge;

  assign ge = (rem >= dshift);

  // Control: count the quotient bits and flag the last one.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= CNT_BITS'(Q_W - 1);
      end else if (busy) begin
        step <= step - 1'b1;
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: compare against the shifted divisor and subtract where it fits.
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      dshift   <= DIVD_W'(divisor) << (Q_W - 1);
      quotient <= '0;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dshift;
      end
      dshift   <= dshift >> 1;
      quotient <= {quotient[Q_W-2:0], ge};
    end
  end

endmodule

FILE: hdl/spc_back.sv
// Back end: tracks the frame peak and its cluster, and produces the result items.
// Depends on spc_pkg and spc_div.
module spc_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [spc_pkg::RAD_W-1:0] cluster_radius_sq,
  input  logic                      q_empty,
  input  spc_pkg::pix_t             q_data,
  output logic                      q_pop,
  output logic                      res_valid,
  input  logic                      res_ready,
  output spc_pkg::result_t          res
);
  import spc_pkg::*;

  back_state_t state, state_next;

  logic [PIX_W-1:0] best_level;
  logic [COL_W-1:0] anchor_col;
  logic [ROW_W-1:0] anchor_row;
  logic [SUM_W-1:0] sum_col, sum_row;
  logic [CNT_W-1:0] member_count;
  logic             anchor_found;
  logic [PIX_W-1:0] last_fused;

  logic             out_free, div_start, emit;
  logic [COL_W-1:0] dx;
  logic [ROW_W-1:0] dy;
  logic [DIST_W-1:0] dist_sq;
  logic             restart, join_cluster;
  logic             div_done_x, div_done_y;
  logic [Q_W-1:0]   quot_x, quot_y;
  logic [DIVD_W-1:0] divd_x, divd_y;
  logic [DIVS_W-1:0] divs;

  assign out_free = !res_valid || res_ready;

  // Sequencer outputs.
  always_comb begin
    q_pop     = (state == BK_IDLE) && !q_empty && out_free;
    div_start = (state == BK_START);
    emit      = (state == BK_EMIT) && out_free;
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (q_pop && q_data.last) begin
          state_next = BK_START;
        end
      end
      BK_START: state_next = BK_DIV;
      BK_DIV: begin
        if (div_done_x && div_done_y) begin
          state_next = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (out_free) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Distance of the current pixel to the cluster anchor and the join decision.
  always_comb begin
    dx = (q_data.x >= anchor_col) ? (q_data.x - anchor_col) : (anchor_col - q_data.x);
    dy = (q_data.y >= anchor_row) ? (q_data.y - anchor_row) : (anchor_row - q_data.y);
    dist_sq = DIST_W'(DIST_W'(dx) * DIST_W'(dx)) + DIST_W'(DIST_W'(dy) * DIST_W'(dy));
    restart = !anchor_found || (q_data.fused > best_level);
    join_cluster = (q_data.fused == best_level) && (member_count != COUNT_MAX) &&
                   ((DIST_W + 1)'(dist_sq) < (DIST_W + 1)'(cluster_radius_sq));
  end

  // Cluster state: a higher level restarts it, the end of a frame clears it.
  always_ff @(posedge clk) begin
    if (rst) begin
      best_level   <= '0;
      anchor_col   <= '0;
      anchor_row   <= '0;
      sum_col      <= '0;
      sum_row      <= '0;
      member_count <= '0;
      anchor_found <= 1'b0;
    end else if (emit) begin
      best_level   <= '0;
      anchor_col   <= '0;
      anchor_row   <= '0;
      sum_col      <= '0;
      sum_row      <= '0;
      member_count <= '0;
      anchor_found <= 1'b0;
    end else if (q_pop) begin
      if (restart) begin
        best_level   <= q_data.fused;
        anchor_col   <= q_data.x;
        anchor_row   <= q_data.y;
        sum_col      <= SUM_W'(q_data.x);
        sum_row      <= SUM_W'(q_data.y);
        member_count <= CNT_W'(1);
        anchor_found <= 1'b1;
      end else if (join_cluster) begin
        sum_col      <= sum_col + SUM_W'(q_data.x);
        sum_row      <= sum_row + SUM_W'(q_data.y);
        member_count <= member_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      last_fused <= q_data.fused;
    end
  end

  // Centroid with halves rounded down: (2 * sum + n - 1) / (2 * n).
  always_comb begin
    divs   = {member_count, 1'b0};
    divd_x = {sum_col, 1'b0} + DIVD_W'(member_count) - DIVD_W'(1);
    divd_y = {sum_row, 1'b0} + DIVD_W'(member_count) - DIVD_W'(1);
  end

  spc_div u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (divd_x),
    .divisor  (divs),
    .done     (div_done_x),
    .quotient (quot_x)
  );

  spc_div u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (divd_y),
    .divisor  (divs),
    .done     (div_done_y),
    .quotient (quot_y)
  );

  // Output register: ordinary pixels leave at once, the frame summary after division.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (q_pop && !q_data.last) begin
      res_valid <= 1'b1;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && !q_data.last) begin
      res <= '{peak_count: '0, peak_level: '0, cent_row: '0, cent_col: '0,
               frame_done: 1'b0, fused_value: q_data.fused};
    end else if (emit) begin
      res <= '{peak_count: member_count, peak_level: best_level,
               cent_row: quot_y[7:0], cent_col: quot_x[8:0],
               frame_done: 1'b1, fused_value: last_fused};
    end
  end

endmodule

FILE: hdl/saliency_peak_centroid.sv
// Top level of the saliency peak centroid block: configuration registers and wiring.
// Depends on spc_pkg, spc_front, spc_fifo, spc_back and spc_div.
//
//   Channel   Direction  Handshake                   Contents
//   s_axis    in         s_axis_tvalid/tready        three saliency samples, tlast ends frame
//   m_axis    out        m_axis_tvalid/tready        fused pixel, centroid summary on frame end
//   cfg       in         cfg_we                      weights and cluster radius
//
// Ordinary pixels pass at one item per clock while the output is not stalled; the front
// fuses and queues them, the back updates the cluster as it pops them. A frame-end pixel
// occupies the back through the pop, the divider start, the quotient-bit steps, a step
// to see the divider finish and one to emit the summary.
// Reset is synchronous; it clears the frame state and restores the register defaults.
// A stalled output holds the back; the four-entry queue keeps the input open meanwhile.
module saliency_peak_centroid (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // converted_value, colour_value, motion_value
  input  logic        s_axis_tlast,   // frame_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // fused_value, cent_col, cent_row, peak_level,
                                      // peak_count, zero padding
  output logic        m_axis_tuser,   // frame_done
  input  logic        cfg_we,
  input  logic [spc_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [spc_pkg::CFG_W-1:0]     cfg_wdata
);
  import spc_pkg::*;

  logic [WEIGHT_W-1:0] weight_colour, weight_converted, weight_motion;
  logic [RAD_W-1:0]    cluster_radius_sq;

  logic    q_push, q_pop, q_full, q_empty;
  pix_t    q_wr, q_rd;
  result_t res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      weight_colour     <= WEIGHT_W'(14564);
      weight_converted  <= WEIGHT_W'(36409);
      weight_motion     <= WEIGHT_W'(14564);
      cluster_radius_sq <= RAD_W'(100);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_WEIGHT_COLOUR:    weight_colour     <= cfg_wdata[WEIGHT_W-1:0];
        REG_WEIGHT_CONVERTED: weight_converted  <= cfg_wdata[WEIGHT_W-1:0];
        REG_WEIGHT_MOTION:    weight_motion     <= cfg_wdata[WEIGHT_W-1:0];
        REG_RADIUS_SQ:        cluster_radius_sq <= cfg_wdata[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  spc_front u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (s_axis_tvalid),
    .in_ready         (s_axis_tready),
    .converted_value  (s_axis_tdata[7:0]),
    .colour_value     (s_axis_tdata[15:8]),
    .motion_value     (s_axis_tdata[23:16]),
    .frame_last       (s_axis_tlast),
    .weight_colour    (weight_colour),
    .weight_converted (weight_converted),
    .weight_motion    (weight_motion),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_data           (q_wr)
  );

  spc_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr),
    .pop     (q_pop),
    .rd_data (q_rd),
    .full    (q_full),
    .empty   (q_empty)
  );

  spc_back u_back (
    .clk               (clk),
    .rst               (rst),
    .cluster_radius_sq (cluster_radius_sq),
    .q_empty           (q_empty),
    .q_data            (q_rd),
    .q_pop             (q_pop),
    .res_valid         (m_axis_tvalid),
    .res_ready         (m_axis_tready),
    .res               (res)
  );

  assign m_axis_tdata = {6'b0, res.peak_count, res.peak_level, res.cent_row,
                         res.cent_col, res.fused_value};
  assign m_axis_tuser = res.frame_done;

  // An ordinary pixel carries no frame summary.
  a_no_summary: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[49:8] == '0)
    else $error("summary fields set on an ordinary pixel");

  // A frame summary always counts at least the anchor pixel.
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[49:33] != '0)
    else $error("frame summary with an empty cluster");

  // The centroid lies inside the frame.
  a_centroid_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[16:8] < 9'(FRAME_WIDTH) && m_axis_tdata[24:17] < 8'(FRAME_HEIGHT))
    else $error("centroid outside the frame");

  // The queue never takes an item while full.
  a_queue_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("queue written while full");

endmodule
